@@ hw/rtl/timed_serial_byte_receiver_unit_macros.svh @@
// Assertion helpers for the serial byte receiver.
// All checks are sampled on the rising clock edge and are off during reset.
`ifndef TIMED_SERIAL_BYTE_RECEIVER_UNIT_MACROS_SVH
`define TIMED_SERIAL_BYTE_RECEIVER_UNIT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define TSBR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the following edge.
`define TSBR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/tsbr_pkg.sv @@
`timescale 1ns / 1ps

package tsbr_pkg;

   // Number of data bits in one received word (1 to 8)
   localparam int DATA_BITS  = 8;
   localparam int BIT_CNT_W  = $clog2(DATA_BITS + 1);

   // Field widths
   localparam int TIMING_W   = 6;
   localparam int VALUE_W    = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   // Register reset values
   localparam logic [TIMING_W-1:0] START_RUN_RST   = 6'd10;
   localparam logic [TIMING_W-1:0] FIRST_DELAY_RST = 6'd3;
   localparam logic [TIMING_W-1:0] BIT_PERIOD_RST  = 6'd4;
   localparam logic [VALUE_W-1:0]  THRESHOLD_RST   = 8'd85;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_RUN   = 2'd0,
      CSR_FIRST_DELAY = 2'd1,
      CSR_BIT_PERIOD  = 2'd2,
      CSR_THRESHOLD   = 2'd3
   } csr_index_type;

   // Receiver phases
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_HUNT = 2'd1,
      PH_DATA = 2'd2
   } phase_type;

endpackage

@@ hw/rtl/timed_serial_byte_receiver_unit.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Transfer when          Payload
// req_      in   req_tvalid & tready    tdata[0] line_level, rest zero
// rsp_      out  rsp_tvalid & tready    tdata[7:0] received_value, [8] pump_on
// csr_      in   csr_wr_en              csr_index selects register, csr_wdata
//
// One line sample is taken per cycle unless the input is stalled; the receiver
// state, and the output register when a byte finishes, load at the clock edge
// that ends the transfer. The only stall is a result still held in the output
// register while rsp_tready is low. Synchronous active-high reset returns the
// receiver to idle and loads the register defaults.

module timed_serial_byte_receiver_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tsbr_pkg::REQ_DATA_W-1:0]     req_tdata,   // [0] line_level
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tsbr_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [7:0] received_value, [8] pump_on
   input  logic                                csr_wr_en,
   input  logic [tsbr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tsbr_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tsbr_pkg::*;

   `include "timed_serial_byte_receiver_unit_macros.svh"

   // Configuration registers
   logic [TIMING_W-1:0] start_run_ff;
   logic [TIMING_W-1:0] first_delay_ff;
   logic [TIMING_W-1:0] bit_period_ff;
   logic [VALUE_W-1:0]  threshold_ff;

   // Receiver state
   phase_type              phase_ff, phase_in;
   logic                   prev_level_ff, prev_level_in;
   logic [TIMING_W-1:0]    run_cnt_ff, run_cnt_in;
   logic [TIMING_W-1:0]    countdown_ff, countdown_in;
   logic [BIT_CNT_W-1:0]   bits_ff, bits_in;
   logic [DATA_BITS-1:0]   shift_ff, shift_in;

   // Output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]     rsp_value_ff, rsp_value_in;
   logic                   rsp_pump_ff, rsp_pump_in;

   logic                   req_xfer;
   logic                   level;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;
   assign level      = req_tdata[0];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_pump_ff, rsp_value_ff};

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_run_ff   <= START_RUN_RST;
         first_delay_ff <= FIRST_DELAY_RST;
         bit_period_ff  <= BIT_PERIOD_RST;
         threshold_ff   <= THRESHOLD_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_START_RUN:   start_run_ff   <= csr_wdata[TIMING_W-1:0];
            CSR_FIRST_DELAY: first_delay_ff <= csr_wdata[TIMING_W-1:0];
            CSR_BIT_PERIOD:  bit_period_ff  <= csr_wdata[TIMING_W-1:0];
            CSR_THRESHOLD:   threshold_ff   <= csr_wdata[VALUE_W-1:0];
            default: ;
         endcase
      end
   end

   // Receiver next state and result
   always_comb begin
      phase_in      = phase_ff;
      prev_level_in = prev_level_ff;
      run_cnt_in    = run_cnt_ff;
      countdown_in  = countdown_ff;
      bits_in       = bits_ff;
      shift_in      = shift_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_pump_in   = rsp_pump_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      if (req_xfer) begin
         // idle: a rising edge opens the start hunt with this same sample
         if (phase_ff != PH_HUNT && phase_ff != PH_DATA) begin
            if (level && !prev_level_ff) begin
               phase_in   = PH_HUNT;
               run_cnt_in = '0;
            end else begin
               phase_in   = PH_IDLE;
            end
         end

         unique case (phase_in)
            PH_HUNT: begin
               if (level) begin
                  run_cnt_in = run_cnt_in + 1'b1;
                  // a zero run length qualifies on the first high sample
                  if (run_cnt_in >= start_run_ff) begin
                     phase_in     = PH_DATA;
                     countdown_in = first_delay_ff;
                     bits_in      = '0;
                     shift_in     = '0;
                     run_cnt_in   = '0;
                  end
               end else begin
                  run_cnt_in = '0;
               end
            end
            PH_DATA: begin
               if (countdown_ff <= TIMING_W'(1)) begin
                  shift_in     = DATA_BITS'({shift_ff, level});
                  bits_in      = bits_ff + 1'b1;
                  countdown_in = bit_period_ff;
                  if (bits_in >= BIT_CNT_W'(DATA_BITS)) begin
                     rsp_value_in = VALUE_W'(shift_in);
                     rsp_pump_in  = (VALUE_W'(shift_in) > threshold_ff);
                     rsp_valid_in = 1'b1;
                     phase_in     = PH_IDLE;
                     bits_in      = '0;
                     countdown_in = '0;
                  end
               end else begin
                  countdown_in = countdown_ff - 1'b1;
               end
            end
            default: ;
         endcase

         prev_level_in = level;
      end
   end

   // State and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         prev_level_ff <= 1'b0;
         run_cnt_ff    <= '0;
         countdown_ff  <= '0;
         bits_ff       <= '0;
         shift_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         prev_level_ff <= prev_level_in;
         run_cnt_ff    <= run_cnt_in;
         countdown_ff  <= countdown_in;
         bits_ff       <= bits_in;
         shift_ff      <= shift_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_pump_ff  <= rsp_pump_in;
   end

   // Checks
   `TSBR_ASSERT_NOW(a_bits_bound, 1'b1, bits_ff < BIT_CNT_W'(DATA_BITS),
      "data bit count reached word length without finishing")
   `TSBR_ASSERT_NEXT(a_result_from_data, !rsp_valid_ff && rsp_valid_in,
      $past(phase_ff == PH_DATA) && phase_ff == PH_IDLE,
      "result produced outside the data phase or without return to idle")
   `TSBR_ASSERT_NOW(a_ready_when_empty, !rsp_valid_ff, req_tready,
      "input stalled with an empty output register")

endmodule

@@ tb/tb_timed_serial_byte_receiver_unit.sv @@
`timescale 1ns / 1ps

module tb_timed_serial_byte_receiver_unit;
   import tsbr_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 400;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               pump;
   } byte_result_type;

   // DUT connections, all inputs known from time zero
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [0] line_level
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [7:0] received_value, [8] pump_on
   logic                  csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // Line samples waiting to be sent, and bytes waiting to come back
   logic            line_samples[$];
   byte_result_type pending_bytes[$];

   // Receiver mirror: register copies and line state
   logic [TIMING_W-1:0]  cfg_run    = START_RUN_RST;
   logic [TIMING_W-1:0]  cfg_delay  = FIRST_DELAY_RST;
   logic [TIMING_W-1:0]  cfg_period = BIT_PERIOD_RST;
   logic [VALUE_W-1:0]   cfg_thresh = THRESHOLD_RST;
   phase_type            rx_phase   = PH_IDLE;
   logic                 rx_prev    = 1'b0;
   logic [TIMING_W-1:0]  rx_run     = '0;
   logic [TIMING_W-1:0]  rx_wait    = '0;
   logic [3:0]           rx_bits    = '0;
   logic [VALUE_W-1:0]   rx_shift   = '0;

   // Run bookkeeping
   int  samples_queued  = 0;
   int  samples_sent    = 0;
   int  bytes_checked   = 0;
   int  mismatches      = 0;
   int  settings_used   = 0;
   int  idle_cycles     = 0;
   int  gap_left        = 0;
   int  stall_left      = 0;
   int  hold_left       = 0;
   bit  hold_done       = 1'b0;
   bit  calm            = 1'b0;
   bit  req_fired       = 1'b0;

   timed_serial_byte_receiver_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 100 MHz clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly no gap, often a short one, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Mirror of the receiver for one line sample; may queue one byte
   task automatic sample_line(input logic lvl);
      if (rx_phase != PH_HUNT && rx_phase != PH_DATA) begin
         if (lvl && !rx_prev) begin
            rx_phase = PH_HUNT;
            rx_run   = '0;
         end else begin
            rx_phase = PH_IDLE;
         end
      end
      if (rx_phase == PH_HUNT) begin
         if (lvl) begin
            rx_run = rx_run + 1'b1;
            // a zero run length qualifies on the first high sample
            if (rx_run >= cfg_run) begin
               rx_phase = PH_DATA;
               rx_wait  = cfg_delay;
               rx_bits  = '0;
               rx_shift = '0;
               rx_run   = '0;
            end
         end else begin
            rx_run = '0;
         end
      end else if (rx_phase == PH_DATA) begin
         if (rx_wait <= 1) begin
            rx_shift = {rx_shift[VALUE_W-2:0], lvl};
            rx_bits  = rx_bits + 1'b1;
            rx_wait  = cfg_period;
            if (rx_bits >= DATA_BITS) begin
               pending_bytes.push_back('{value: rx_shift, pump: rx_shift > cfg_thresh});
               rx_phase = PH_IDLE;
               rx_bits  = '0;
               rx_wait  = '0;
            end
         end else begin
            rx_wait = rx_wait - 1'b1;
         end
      end
      rx_prev = lvl;
   endtask

   // Monitor: register writes, input transfers and result checks
   always @(posedge clock) begin
      byte_result_type want;
      if (reset) begin
         req_fired = 1'b0;
      end else begin
         req_fired = req_tvalid && req_tready;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_START_RUN:   cfg_run    = csr_wdata[TIMING_W-1:0];
               CSR_FIRST_DELAY: cfg_delay  = csr_wdata[TIMING_W-1:0];
               CSR_BIT_PERIOD:  cfg_period = csr_wdata[TIMING_W-1:0];
               CSR_THRESHOLD:   cfg_thresh = csr_wdata[VALUE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            bytes_checked++;
            if (pending_bytes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result with none expected: value %02h pump %0b",
                           $realtime, rsp_tdata[7:0], rsp_tdata[8]);
            end else begin
               want = pending_bytes.pop_front();
               if (rsp_tdata[7:0] !== want.value || rsp_tdata[8] !== want.pump) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: byte %0d expected value %02h pump %0b, got %02h pump %0b",
                              $realtime, bytes_checked, want.value, want.pump,
                              rsp_tdata[7:0], rsp_tdata[8]);
               end
            end
         end
         if (req_fired) begin
            samples_sent++;
            sample_line(req_tdata[0]);
         end
      end
   end

   // Sender: one line sample per transfer, with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else if (!req_tvalid || req_fired) begin
         if (gap_left > 0) begin
            req_tvalid <= 1'b0;
            gap_left--;
         end else if (line_samples.size() > 0) begin
            req_tdata  <= {{(REQ_DATA_W-1){1'b0}}, line_samples.pop_front()};
            req_tvalid <= 1'b1;
            gap_left = pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver side: random stalls, plus one long hold once a few bytes are in
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (!hold_done && bytes_checked >= 4) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d bytes outstanding",
                     $realtime, idle_cycles, pending_bytes.size());
            $display("FAIL timed_serial_byte_receiver_unit");
            $finish;
         end
      end
   end

   task automatic queue_level(input logic lvl);
      line_samples.push_back(lvl);
      samples_queued++;
   endtask

   // Wait until every sample is sent and every byte is back, then let the
   // output register settle before touching the registers
   task automatic wait_drained();
      do
         @(posedge clock);
      while (line_samples.size() != 0 || req_tvalid || pending_bytes.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Well-formed frame at the current timing: low lead-in, start pulse
   // (sometimes preceded by a broken run), then the data bits MSB first
   task automatic queue_frame(input logic [VALUE_W-1:0] value);
      int run_len;
      int spacing;
      int k;
      run_len = (cfg_run == 0) ? 1 : cfg_run;
      repeat ($urandom_range(1, 3)) queue_level(1'b0);
      if (run_len > 1 && $urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, run_len - 1)) queue_level(1'b1);
         repeat ($urandom_range(1, 2)) queue_level(1'b0);
      end
      repeat (run_len) queue_level(1'b1);
      for (k = DATA_BITS - 1; k >= 0; k--) begin
         spacing = (k == DATA_BITS - 1) ? cfg_delay : cfg_period;
         if (spacing == 0)
            spacing = 1;
         repeat (spacing - 1) queue_level(1'($urandom_range(0, 1)));
         queue_level(value[k]);
      end
   endtask

   // One register setting followed by random frames and some noise
   task automatic run_setting(input logic [CSR_DATA_W-1:0] run_v,
                              input logic [CSR_DATA_W-1:0] delay_v,
                              input logic [CSR_DATA_W-1:0] period_v,
                              input logic [CSR_DATA_W-1:0] thresh_v,
                              input int budget, input bit quiet);
      int stop_at;
      int pick;
      logic [VALUE_W-1:0] value;
      wait_drained();
      write_reg(CSR_START_RUN, run_v);
      write_reg(CSR_FIRST_DELAY, delay_v);
      write_reg(CSR_BIT_PERIOD, period_v);
      write_reg(CSR_THRESHOLD, thresh_v);
      @(posedge clock);
      settings_used++;
      calm = quiet;
      stop_at = samples_queued + budget;
      do begin
         pick = $urandom_range(0, 9);
         case (pick)
            0: value = '0;
            1: value = '1;
            2: value = cfg_thresh;
            3: value = cfg_thresh + 1'b1;
            default: value = VALUE_W'($urandom_range(0, 255));
         endcase
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(3, 20)) queue_level(1'($urandom_range(0, 1)));
         queue_frame(value);
      end while (samples_queued < stop_at);
   endtask

   // Stimulus sequence
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: tightest timing, reset threshold; start right out of reset,
      // all ones, all zeros, and a value equal to the threshold
      write_reg(CSR_START_RUN, 8'd1);
      write_reg(CSR_FIRST_DELAY, 8'd1);
      write_reg(CSR_BIT_PERIOD, 8'd1);
      @(posedge clock);
      settings_used++;
      repeat (9) queue_level(1'b1);
      queue_level(1'b0);
      queue_level(1'b1);
      repeat (8) queue_level(1'b0);
      queue_level(1'b0);
      queue_level(1'b1);
      queue_frame_bits: for (int b = 7; b >= 0; b--)
         queue_level(b[0] == 1'b0);

      // Random settings, extremes among them
      run_setting(8'd10, 8'd3, 8'd4, 8'd85, 250, 1'b0);
      run_setting(8'd0, 8'd0, 8'd0, 8'd0, 200, 1'b1);
      run_setting(8'd63, 8'd63, 8'd63, 8'd255, 150, 1'b0);
      // upper write bits of a timing register are dropped
      run_setting(8'd2, 8'd2, 8'hC1, 8'd200, 200, 1'b0);
      run_setting(CSR_DATA_W'($urandom_range(1, 8)), CSR_DATA_W'($urandom_range(1, 8)),
                  CSR_DATA_W'($urandom_range(1, 4)), CSR_DATA_W'($urandom_range(0, 255)),
                  200, 1'b0);

      wait_drained();
      repeat (10) @(posedge clock);
      $display("Sent %0d line samples and checked %0d bytes over %0d register settings,",
               samples_sent, bytes_checked, settings_used);
      $display("with zero and full-scale timing, threshold edges and a long output hold.");
      if (mismatches == 0 && pending_bytes.size() == 0) begin
         $display("PASS timed_serial_byte_receiver_unit");
      end else begin
         $display("%0d mismatches, %0d bytes never arrived", mismatches, pending_bytes.size());
         $display("FAIL timed_serial_byte_receiver_unit");
      end
      $finish;
   end

endmodule
